// ===== sv/cstb_pkg.sv =====
package cstb_pkg;

   localparam int CYCLE_W = 32;
   localparam int DATA_W  = 8;
   localparam int INDEX_W = 10;
   localparam int HELD_W  = 11;

   typedef enum logic [1:0] {
      OP_APPEND   = 2'd0,
      OP_READ     = 2'd1,
      OP_SET_DATA = 2'd2,
      OP_CLEAR    = 2'd3
   } cstb_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } cstb_state_type;

   // read and write enables act at one shared address
   typedef struct packed {
      logic stamp_we;
      logic byte_we;
      logic rd_en;
   } cstb_mem_ctl_type;

endpackage

// ===== sv/cstb_ring_mem.sv =====
module cstb_ring_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  cstb_pkg::cstb_mem_ctl_type        ctl,
   input  logic [$clog2(DEPTH)-1:0]          addr,
   input  logic [cstb_pkg::CYCLE_W-1:0]      wr_stamp,
   input  logic [cstb_pkg::DATA_W-1:0]       wr_byte,
   output logic [cstb_pkg::CYCLE_W-1:0]      rd_stamp,
   output logic [cstb_pkg::DATA_W-1:0]       rd_byte
);
   import cstb_pkg::*;

   logic [CYCLE_W-1:0] stamp_mem [DEPTH];
   logic [DATA_W-1:0]  byte_mem  [DEPTH];
   logic [CYCLE_W-1:0] rd_stamp_ff;
   logic [DATA_W-1:0]  rd_byte_ff;

   // read-first single port
   always_ff @(posedge clock) begin
      if (ctl.stamp_we) begin
         stamp_mem[addr] <= wr_stamp;
      end
      if (ctl.byte_we) begin
         byte_mem[addr] <= wr_byte;
      end
      if (ctl.rd_en) begin
         rd_stamp_ff <= stamp_mem[addr];
         rd_byte_ff  <= byte_mem[addr];
      end
   end

   assign rd_stamp = rd_stamp_ff;
   assign rd_byte  = rd_byte_ff;

endmodule

// ===== sv/circular_sample_trace_buffer_unit.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  op, cycle_stamp, data_byte, index
// rsp_      out        rsp_valid / rsp_stall  entry_*, newest_*, held_count
//
// Append, clear and out-of-range read/set-data: result registered on the
// accepting edge.
// In-range read/set-data: the registered read of the single-port sample
// memory passes through the lookup state; req_stall is high in that state.
// Synchronous active-high reset clears pointers, count and handshake state;
// the sample memory is not cleared (entries are only read once written).
// A held result blocks new transactions only while rsp_stall is high.
module circular_sample_trace_buffer_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [cstb_pkg::CYCLE_W-1:0]      req_cycle_stamp,
   input  logic [cstb_pkg::DATA_W-1:0]       req_data_byte,
   input  logic [cstb_pkg::INDEX_W-1:0]      req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cstb_pkg::CYCLE_W-1:0]      rsp_entry_cycle,
   output logic [cstb_pkg::DATA_W-1:0]       rsp_entry_data,
   output logic                              rsp_entry_valid,
   output logic [cstb_pkg::CYCLE_W-1:0]      rsp_newest_cycle,
   output logic [cstb_pkg::DATA_W-1:0]       rsp_newest_data,
   output logic                              rsp_newest_valid,
   output logic [cstb_pkg::HELD_W-1:0]       rsp_held_count
);
   import cstb_pkg::*;

   localparam int AW = $clog2(DEPTH);          // ring slot
   localparam int CW = $clog2(DEPTH + 1);      // held count
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   // Pointer and count state
   cstb_state_type     state_ff, state_in;
   logic [AW-1:0]      wr_pos_ff, wr_pos_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [CW-1:0]      count_ff, count_in;
   // Copy of the newest sample, kept in step with appends and set-data
   logic [AW-1:0]      newest_pos_ff, newest_pos_in;
   logic [CYCLE_W-1:0] newest_cycle_ff, newest_cycle_in;
   logic [DATA_W-1:0]  newest_data_ff, newest_data_in;
   // Pending lookup
   cstb_op_type        pend_op_ff, pend_op_in;
   logic [DATA_W-1:0]  pend_byte_ff, pend_byte_in;
   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CYCLE_W-1:0] entry_cycle_ff, entry_cycle_in;
   logic [DATA_W-1:0]  entry_data_ff, entry_data_in;
   logic               entry_valid_ff, entry_valid_in;
   logic [CYCLE_W-1:0] out_newest_cycle_ff, out_newest_cycle_in;
   logic [DATA_W-1:0]  out_newest_data_ff, out_newest_data_in;
   logic               out_newest_valid_ff, out_newest_valid_in;
   logic [CW-1:0]      held_ff, held_in;

   cstb_mem_ctl_type   mem_ctl;
   logic [AW-1:0]      mem_addr;
   logic [CYCLE_W-1:0] mem_rd_stamp;
   logic [DATA_W-1:0]  mem_rd_byte;

   cstb_op_type        op;
   logic               req_fire;
   logic               rsp_free;
   logic               index_ok;
   logic [SW-1:0]      slot_sum;
   logic [AW-1:0]      slot;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == LAST_SLOT) ? '0 : p + AW'(1);
      return r;
   endfunction

   assign op       = cstb_op_type'(req_op);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_LOOKUP) || !rsp_free;
   assign req_fire = req_valid && !req_stall;

   // Held position: oldest + index, wrapped once (index < count <= DEPTH when used)
   assign index_ok = XW'(req_index) < XW'(count_ff);
   assign slot_sum = SW'(oldest_ff) + SW'(req_index);
   assign slot     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);

   always_comb begin
      state_in            = state_ff;
      wr_pos_in           = wr_pos_ff;
      oldest_in           = oldest_ff;
      count_in            = count_ff;
      newest_pos_in       = newest_pos_ff;
      newest_cycle_in     = newest_cycle_ff;
      newest_data_in      = newest_data_ff;
      pend_op_in          = pend_op_ff;
      pend_byte_in        = pend_byte_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      entry_cycle_in      = entry_cycle_ff;
      entry_data_in       = entry_data_ff;
      entry_valid_in      = entry_valid_ff;
      out_newest_cycle_in = out_newest_cycle_ff;
      out_newest_data_in  = out_newest_data_ff;
      out_newest_valid_in = out_newest_valid_ff;
      held_in             = held_ff;
      mem_ctl             = '0;
      mem_addr            = slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (op)
                  OP_APPEND: begin
                     mem_addr         = wr_pos_ff;
                     mem_ctl.stamp_we = 1'b1;
                     mem_ctl.byte_we  = 1'b1;
                     wr_pos_in        = wrap_inc(wr_pos_ff);
                     if (count_ff == FULL_COUNT) begin
                        oldest_in = wrap_inc(oldest_ff);
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                     newest_pos_in       = wr_pos_ff;
                     newest_cycle_in     = req_cycle_stamp;
                     newest_data_in      = req_data_byte;
                     rsp_valid_in        = 1'b1;
                     entry_cycle_in      = req_cycle_stamp;
                     entry_data_in       = req_data_byte;
                     entry_valid_in      = 1'b1;
                     out_newest_cycle_in = req_cycle_stamp;
                     out_newest_data_in  = req_data_byte;
                     out_newest_valid_in = 1'b1;
                     held_in             = count_in;
                  end
                  OP_READ, OP_SET_DATA: begin
                     if (index_ok) begin
                        mem_ctl.rd_en = 1'b1;
                        pend_op_in    = op;
                        pend_byte_in  = req_data_byte;
                        state_in      = ST_LOOKUP;
                        if (op == OP_SET_DATA) begin
                           mem_ctl.byte_we = 1'b1;
                           if (slot == newest_pos_ff) begin
                              newest_data_in = req_data_byte;
                           end
                        end
                     end else begin
                        // out of range: no access, entry reads as zeros
                        rsp_valid_in        = 1'b1;
                        entry_cycle_in      = '0;
                        entry_data_in       = '0;
                        entry_valid_in      = 1'b0;
                        out_newest_valid_in = count_ff != '0;
                        out_newest_cycle_in = out_newest_valid_in ? newest_cycle_ff : '0;
                        out_newest_data_in  = out_newest_valid_in ? newest_data_ff : '0;
                        held_in             = count_ff;
                     end
                  end
                  OP_CLEAR: begin
                     wr_pos_in           = '0;
                     oldest_in           = '0;
                     count_in            = '0;
                     rsp_valid_in        = 1'b1;
                     entry_cycle_in      = '0;
                     entry_data_in       = '0;
                     entry_valid_in      = 1'b0;
                     out_newest_cycle_in = '0;
                     out_newest_data_in  = '0;
                     out_newest_valid_in = 1'b0;
                     held_in             = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOKUP: begin
            // memory data is here; result register is free (drained on accept)
            state_in            = ST_IDLE;
            rsp_valid_in        = 1'b1;
            entry_cycle_in      = mem_rd_stamp;
            entry_data_in       = (pend_op_ff == OP_SET_DATA) ? pend_byte_ff : mem_rd_byte;
            entry_valid_in      = 1'b1;
            out_newest_cycle_in = newest_cycle_ff;
            out_newest_data_in  = newest_data_ff;
            out_newest_valid_in = 1'b1;
            held_in             = count_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_pos_ff    <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pos_ff    <= wr_pos_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_pos_ff       <= newest_pos_in;
      newest_cycle_ff     <= newest_cycle_in;
      newest_data_ff      <= newest_data_in;
      pend_op_ff          <= pend_op_in;
      pend_byte_ff        <= pend_byte_in;
      entry_cycle_ff      <= entry_cycle_in;
      entry_data_ff       <= entry_data_in;
      entry_valid_ff      <= entry_valid_in;
      out_newest_cycle_ff <= out_newest_cycle_in;
      out_newest_data_ff  <= out_newest_data_in;
      out_newest_valid_ff <= out_newest_valid_in;
      held_ff             <= held_in;
   end

   cstb_ring_mem #(
      .DEPTH(DEPTH)
   ) u_ring_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .addr     (mem_addr),
      .wr_stamp (req_cycle_stamp),
      .wr_byte  (req_data_byte),
      .rd_stamp (mem_rd_stamp),
      .rd_byte  (mem_rd_byte)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_cycle  = entry_cycle_ff;
   assign rsp_entry_data   = entry_data_ff;
   assign rsp_entry_valid  = entry_valid_ff;
   assign rsp_newest_cycle = out_newest_cycle_ff;
   assign rsp_newest_data  = out_newest_data_ff;
   assign rsp_newest_valid = out_newest_valid_ff;
   assign rsp_held_count   = HELD_W'(held_ff);

endmodule

// ===== test/circular_sample_trace_buffer_unit_tb.sv =====
`timescale 1ns / 100ps

module circular_sample_trace_buffer_unit_tb;
   import cstb_pkg::*;

   // Full-size ring, as the block is normally built. Filling it past the
   // top takes a long append-heavy phase, which the fill test provides.
   localparam int RING_DEPTH  = 1024;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 50;

   // One predicted result transaction, at the port widths
   typedef struct {
      logic [CYCLE_W-1:0] entry_cycle;
      logic [DATA_W-1:0]  entry_data;
      logic               entry_valid;
      logic [CYCLE_W-1:0] newest_cycle;
      logic [DATA_W-1:0]  newest_data;
      logic               newest_valid;
      logic [HELD_W-1:0]  held_count;
   } trace_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [CYCLE_W-1:0] req_cycle_stamp;
   logic [DATA_W-1:0]  req_data_byte;
   logic [INDEX_W-1:0] req_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CYCLE_W-1:0] rsp_entry_cycle;
   logic [DATA_W-1:0]  rsp_entry_data;
   logic               rsp_entry_valid;
   logic [CYCLE_W-1:0] rsp_newest_cycle;
   logic [DATA_W-1:0]  rsp_newest_data;
   logic               rsp_newest_valid;
   logic [HELD_W-1:0]  rsp_held_count;

   // Shadow copy of the ring, kept in step with accepted requests
   logic [CYCLE_W-1:0] ring_stamp [RING_DEPTH];
   logic [DATA_W-1:0]  ring_byte [RING_DEPTH];
   int unsigned        wr_pos;
   int unsigned        oldest_pos;
   int unsigned        held;

   trace_result_type   trace_result_q [$];
   trace_result_type   want;

   int unsigned        mismatch_count;
   int unsigned        results_checked;
   int unsigned        requests_sent;
   int unsigned        cycle_count;
   bit                 idle_on;

   circular_sample_trace_buffer_unit #(
      .DEPTH(RING_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_cycle_stamp  (req_cycle_stamp),
      .req_data_byte    (req_data_byte),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_cycle  (rsp_entry_cycle),
      .rsp_entry_data   (rsp_entry_data),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_newest_cycle (rsp_newest_cycle),
      .rsp_newest_data  (rsp_newest_data),
      .rsp_newest_valid (rsp_newest_valid),
      .rsp_held_count   (rsp_held_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Hang guard: generous multiple of the slowest legal run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("cycle limit of %0d reached with %0d results outstanding",
               CYCLE_LIMIT, trace_result_q.size());
      $display("circular_sample_trace_buffer_unit_tb failed");
      $finish;
   end

   // Applies one operation to the shadow ring and returns the result the
   // block should produce for it. Index beyond the held count leaves the
   // entry fields at zero; set data then writes nothing.
   function automatic trace_result_type step_trace_ring(cstb_op_type op,
                                                        logic [CYCLE_W-1:0] stamp_val,
                                                        logic [DATA_W-1:0] byte_val,
                                                        logic [INDEX_W-1:0] idx_val);
      trace_result_type     r;
      logic [RING_AW-1:0]   slot;
      r = '{default: '0};
      case (op)
         OP_APPEND: begin
            slot             = RING_AW'(wr_pos);
            ring_stamp[slot] = stamp_val;
            ring_byte[slot]  = byte_val;
            wr_pos           = (wr_pos + 1) % RING_DEPTH;
            // full ring: the oldest sample is overwritten
            if (held < RING_DEPTH)
               held = held + 1;
            else
               oldest_pos = (oldest_pos + 1) % RING_DEPTH;
            r.entry_cycle = stamp_val;
            r.entry_data  = byte_val;
            r.entry_valid = 1'b1;
         end
         OP_READ, OP_SET_DATA: begin
            if (idx_val < held) begin
               slot = RING_AW'((oldest_pos + idx_val) % RING_DEPTH);
               if (op == OP_SET_DATA)
                  ring_byte[slot] = byte_val;
               r.entry_cycle = ring_stamp[slot];
               r.entry_data  = ring_byte[slot];
               r.entry_valid = 1'b1;
            end
         end
         OP_CLEAR: begin
            wr_pos     = 0;
            oldest_pos = 0;
            held       = 0;
         end
      endcase
      if (held > 0) begin
         slot           = RING_AW'((wr_pos + RING_DEPTH - 1) % RING_DEPTH);
         r.newest_cycle = ring_stamp[slot];
         r.newest_data  = ring_byte[slot];
         r.newest_valid = 1'b1;
      end
      r.held_count = HELD_W'(held);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [CYCLE_W-1:0] got,
                                  logic [CYCLE_W-1:0] wanted);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: result %0d %s mismatch: got %0h, wanted %0h",
                  $realtime, results_checked, what, got, wanted);
   endtask

   // Result checker: every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (trace_result_q.size() == 0) begin
            report_mismatch("unexpected transaction", '0, '0);
         end else begin
            want = trace_result_q.pop_front();
            if (rsp_entry_cycle !== want.entry_cycle)
               report_mismatch("entry_cycle", rsp_entry_cycle, want.entry_cycle);
            if (rsp_entry_data !== want.entry_data)
               report_mismatch("entry_data", CYCLE_W'(rsp_entry_data),
                               CYCLE_W'(want.entry_data));
            if (rsp_entry_valid !== want.entry_valid)
               report_mismatch("entry_valid", CYCLE_W'(rsp_entry_valid),
                               CYCLE_W'(want.entry_valid));
            if (rsp_newest_cycle !== want.newest_cycle)
               report_mismatch("newest_cycle", rsp_newest_cycle, want.newest_cycle);
            if (rsp_newest_data !== want.newest_data)
               report_mismatch("newest_data", CYCLE_W'(rsp_newest_data),
                               CYCLE_W'(want.newest_data));
            if (rsp_newest_valid !== want.newest_valid)
               report_mismatch("newest_valid", CYCLE_W'(rsp_newest_valid),
                               CYCLE_W'(want.newest_valid));
            if (rsp_held_count !== want.held_count)
               report_mismatch("held_count", CYCLE_W'(rsp_held_count),
                               CYCLE_W'(want.held_count));
         end
         results_checked++;
      end
   end

   // Receiver back-pressure: stall bursts between gaps of varying length,
   // some long enough to give clean stretches. Nothing once idling is
   // switched off.
   initial begin
      int unsigned gap;
      int unsigned burst;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (!idle_on) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 30);
            burst = $urandom_range(1, 15);
            rsp_stall <= 1'b0;
            repeat (gap) @(posedge clock);
            if (idle_on) begin
               rsp_stall <= 1'b1;
               repeat (burst) @(posedge clock);
            end
         end
      end
   end

   // Sends one request transaction. An optional idle burst comes first,
   // with junk on the payload while valid is low. Valid stays high from one
   // transaction to the next when there is no burst. The prediction is
   // made at the accepting edge, so it sees every earlier request.
   task automatic send_sample_op(cstb_op_type op, logic [CYCLE_W-1:0] stamp_val,
                                 logic [DATA_W-1:0] byte_val,
                                 logic [INDEX_W-1:0] idx_val);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) begin
            req_op          <= 2'($urandom_range(0, 3));
            req_cycle_stamp <= $urandom;
            req_data_byte   <= DATA_W'($urandom);
            req_index       <= INDEX_W'($urandom);
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_cycle_stamp <= stamp_val;
      req_data_byte   <= byte_val;
      req_index       <= idx_val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trace_result_q.push_back(step_trace_ring(op, stamp_val, byte_val, idx_val));
      requests_sent++;
   endtask

   // Random operation mix. Indices mostly land on held samples; the rest
   // span the full field so that out-of-range cases keep turning up.
   task automatic send_random_op(int unsigned append_pct, int unsigned clear_pct);
      int unsigned        pick;
      cstb_op_type        op;
      logic [INDEX_W-1:0] idx_val;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct)
         op = OP_CLEAR;
      else if (pick < clear_pct + append_pct)
         op = OP_APPEND;
      else
         op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_SET_DATA;
      if (held > 0 && $urandom_range(0, 4) != 0)
         idx_val = INDEX_W'($urandom_range(0, held - 1));
      else
         idx_val = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
      send_sample_op(op, $urandom, DATA_W'($urandom), idx_val);
   endtask

   task automatic apply_reset();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_APPEND;
      req_cycle_stamp <= '0;
      req_data_byte   <= '0;
      req_index       <= '0;
      wr_pos          = 0;
      oldest_pos      = 0;
      held            = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   endtask

   // Edge cases: empty ring, field extremes, out-of-range index,
   // set data on held and not held samples, clear and reuse
   task automatic test_directed_cases();
      send_sample_op(OP_READ,     '0,           '0,    '0);
      send_sample_op(OP_SET_DATA, '1,           8'h5a, '0);
      send_sample_op(OP_CLEAR,    '1,           '1,    '1);
      send_sample_op(OP_APPEND,   '0,           '0,    '1);
      send_sample_op(OP_APPEND,   '1,           '1,    '0);
      send_sample_op(OP_READ,     '0,           '0,    10'd0);
      send_sample_op(OP_READ,     '1,           '1,    10'd1);
      send_sample_op(OP_READ,     '0,           '0,    10'd2);
      send_sample_op(OP_READ,     '0,           '0,    '1);
      send_sample_op(OP_SET_DATA, 32'h1234_5678, 8'ha5, 10'd1);
      send_sample_op(OP_READ,     '0,           '0,    10'd1);
      send_sample_op(OP_SET_DATA, '0,           8'h3c, 10'd5);
      send_sample_op(OP_SET_DATA, '0,           '1,    '1);
      send_sample_op(OP_APPEND,   32'hdead_beef, 8'h81, '0);
      send_sample_op(OP_READ,     '0,           '0,    10'd2);
      send_sample_op(OP_CLEAR,    '0,           '0,    '0);
      send_sample_op(OP_READ,     '0,           '0,    10'd0);
      send_sample_op(OP_APPEND,   32'h8000_0001, 8'h7e, 10'd512);
      send_sample_op(OP_SET_DATA, '1,           8'h00, 10'd0);
      send_sample_op(OP_READ,     '0,           '0,    10'd0);
   endtask

   // Mixed traffic with frequent clears: short rings, lots of empty cases
   task automatic test_mixed_traffic();
      repeat (300) send_random_op(55, 4);
   endtask

   // Appends dominate until the ring fills and then roughly a hundred more
   // land on top, so held positions straddle the top of the store and the
   // oldest sample keeps being overwritten. Ends on the first and last held
   // samples.
   task automatic test_fill_and_wrap();
      send_sample_op(OP_CLEAR, '0, '0, '0);
      repeat (1200) send_random_op(95, 0);
      send_sample_op(OP_READ, '0, '0, '0);
      send_sample_op(OP_READ, '0, '0, INDEX_W'(held - 1));
      send_sample_op(OP_SET_DATA, '0, DATA_W'($urandom), INDEX_W'(held - 1));
   endtask

   // Back-to-back transactions, no idling on either side
   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (150) send_random_op(50, 2);
   endtask

   // Drains outstanding results, allows a short settle for stray ones,
   // then gives the verdict
   task automatic finish_run();
      req_valid <= 1'b0;
      while (trace_result_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d request transactions, %0d results checked, %0d mismatches",
               requests_sent, results_checked, mismatch_count);
      $display("covered empty ring, out-of-range index, clear, fill past depth, wrap");
      if (mismatch_count == 0)
         $display("circular_sample_trace_buffer_unit_tb passed");
      else
         $display("circular_sample_trace_buffer_unit_tb failed");
      $finish;
   endtask

   initial begin
      mismatch_count  = 0;
      results_checked = 0;
      requests_sent   = 0;
      cycle_count     = 0;
      idle_on         = 1'b1;
      apply_reset();
      test_directed_cases();
      test_mixed_traffic();
      test_fill_and_wrap();
      test_back_to_back();
      finish_run();
   end

endmodule
